// ----- rtl/floppy_soft_switch_controller_assert.svh -----
// assertion macros for the soft-switch block
`ifndef FLOPPY_SOFT_SWITCH_CONTROLLER_ASSERT_SVH
`define FLOPPY_SOFT_SWITCH_CONTROLLER_ASSERT_SVH
// implication checked on every rising clock edge outside reset
`define FSSC_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// next-cycle implication checked outside reset
`define FSSC_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

// ----- rtl/fssc_pkg.sv -----
// ----------------------------------------------------------------------------
// fssc_pkg
// shared constants and types of the soft-switch block
// ----------------------------------------------------------------------------
`default_nettype none
package fssc_pkg;
   localparam int NibblesPerTrack = 6656;
   localparam int TrackCount      = 35;
   localparam int MaxHalfTrack    = 68;
   localparam int DriveNibbles    = TrackCount * NibblesPerTrack;
   localparam int StoreDepth      = 2 * DriveNibbles;
   localparam int StoreAw         = $clog2(StoreDepth);
   localparam int PosW            = $clog2(NibblesPerTrack);
   localparam int TrackW          = $clog2(TrackCount);
   localparam int HalfW           = $clog2(MaxHalfTrack + 1);
   localparam int OffW            = 18;

   localparam logic [1:0] REQ_BUS  = 2'd0;
   localparam logic [1:0] REQ_KEY  = 2'd1;
   localparam logic [1:0] REQ_LOAD = 2'd2;

   localparam logic [15:0] ADDR_KBD    = 16'hC000;
   localparam logic [15:0] ADDR_STROBE = 16'hC010;
   localparam logic [15:0] ADDR_LATCH  = 16'hC0EC;
   localparam logic [15:0] ADDR_LOAD   = 16'hC0ED;
   localparam logic [15:0] ADDR_RDMODE = 16'hC0EE;
   localparam logic [15:0] ADDR_WRMODE = 16'hC0EF;
   localparam logic [15:0] ADDR_MOTOFF = 16'hC0E8;
   localparam logic [15:0] ADDR_MOTON  = 16'hC0E9;
   localparam logic [15:0] ADDR_SEL0   = 16'hC0EA;
   localparam logic [15:0] ADDR_SEL1   = 16'hC0EB;
   localparam logic [15:0] ADDR_ROMOFF = 16'hCFFF;

   localparam logic [0:0] CSR_WP = 1'd0;

   // store access request from the control path
   typedef struct packed {
      logic               rd;
      logic               wr;
      logic [StoreAw-1:0] addr;
      logic [7:0]         wdata;
   } store_req_type;
endpackage
`default_nettype wire

// ----- rtl/fssc_store.sv -----
// ----------------------------------------------------------------------------
// fssc_store
// nibble image store of both drives, one port, registered read
// ----------------------------------------------------------------------------
`default_nettype none
module fssc_store import fssc_pkg::*; (
   input  wire logic          clock,
   input  wire store_req_type req,
   output logic [7:0]         rdata
);
   logic [7:0] mem [StoreDepth];
   logic [7:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (req.wr) begin
         mem[req.addr] <= req.wdata;
      end
      if (req.rd) begin
         rdata_ff <= mem[req.addr];
      end
   end
   assign rdata = rdata_ff;
endmodule
`default_nettype wire

// ----- rtl/floppy_soft_switch_controller.sv -----
// ----------------------------------------------------------------------------
// floppy_soft_switch_controller
// i/o page soft switches, language card control and two-drive nibble floppy
// ----------------------------------------------------------------------------
// channel  dir  contents
// req      in   tdata: req_type, address, is_write, write_data, key_code,
//                      load_drive, image_offset, image_byte
// rsp      out  tdata: read_data, text_on ... drive_selected
// csr      in   apb write_protect at address 0
//
// one transfer per cycle while the result side is not stalled; the latch read at
// c0ec reads the store in the accept cycle and the byte is driven from the store's
// read register in the next cycle (two-stage path: accept stage, result stage)
// sync reset clears the state flags but sets text; the image store is not cleared
// req_tready follows the result stage: a new transfer enters whenever the
// result register is empty or drains in the same cycle
`default_nettype none
`include "floppy_soft_switch_controller_assert.svh"
module floppy_soft_switch_controller import fssc_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // type[1:0] addr[17:2] wr[18] wdata[26:19] key[34:27] drv[35]
   // off[53:36] byte[61:54] pad[63:62]
   input  wire logic [63:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // read_data[7:0] text[8] mixed[9] page[10] hires[11] bank[12]
   // rdram[13] wrram[14] motor[15] drive[16] pad[23:17]
   output logic [23:0]      rsp_tdata,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [0:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   logic [1:0]  rtype;
   logic [15:0] addr;
   logic        iswr, ldrv;
   logic [7:0]  wdat, kcode, ibyte;
   logic [OffW-1:0] ioff;
   assign rtype = req_tdata[1:0];
   assign addr  = req_tdata[17:2];
   assign iswr  = req_tdata[18];
   assign wdat  = req_tdata[26:19];
   assign kcode = req_tdata[34:27];
   assign ldrv  = req_tdata[35];
   assign ioff  = req_tdata[53:36];
   assign ibyte = req_tdata[61:54];

   logic [1:0] wp_ff;
   assign csr_pready = 1'b1;
   assign csr_prdata = {30'd0, wp_ff};

   logic [7:0] key_ff, key_in, shl_ff, shl_in, tick_ff, tick_in;
   logic text_ff, text_in, mixed_ff, mixed_in, page_ff, page_in, hires_ff, hires_in;
   logic bank_ff, bank_in, rdr_ff, rdr_in, wrr_ff, wrr_in, pre_ff, pre_in;
   logic drv_ff, drv_in;
   logic [1:0] mot_ff, mot_in, wm_ff, wm_in;
   logic [TrackW-1:0] trk_ff [2];
   logic [TrackW-1:0] trk_in [2];
   logic [PosW-1:0]   pos_ff [2];
   logic [PosW-1:0]   pos_in [2];
   logic [3:0] pn_ff [2];
   logic [3:0] pn_in [2];
   logic [3:0] pp_ff [2];
   logic [3:0] pp_in [2];
   logic [3:0] pp2_ff [2];
   logic [3:0] pp2_in [2];
   logic [1:0] pi_ff [2];
   logic [1:0] pi_in [2];
   logic [1:0] pip_ff [2];
   logic [1:0] pip_in [2];
   logic [HalfW-1:0] ht_ff [2];
   logic [HalfW-1:0] ht_in [2];

   // result stage
   logic        rv_ff, rv_in;
   logic        rfs_ff, rfs_in;   // read data comes from the store
   logic [7:0]  rd_ff, rd_in;
   logic [8:0]  rflags_ff, rflags_in;
   logic [7:0]  srd;
   logic        acc;
   store_req_type sreq;

   fssc_store u_store (.clock(clock), .req(sreq), .rdata(srd));

   assign req_tready = !rv_ff || rsp_tready;
   assign acc        = req_tvalid && req_tready;
   assign rsp_tvalid = rv_ff;
   assign rsp_tdata  = {7'd0, rflags_ff, (rfs_ff ? srd : rd_ff)};

   always_comb begin
      logic d;
      logic [1:0] ph, ip, ic;
      logic [3:0] np2;
      logic [HalfW-1:0] h;
      logic [HalfW:0] tt;
      logic [StoreAw-1:0] base;
      d = drv_ff;
      key_in = key_ff; shl_in = shl_ff; tick_in = tick_ff;
      text_in = text_ff; mixed_in = mixed_ff; page_in = page_ff; hires_in = hires_ff;
      bank_in = bank_ff; rdr_in = rdr_ff; wrr_in = wrr_ff; pre_in = pre_ff;
      drv_in = drv_ff; mot_in = mot_ff; wm_in = wm_ff;
      trk_in = trk_ff; pos_in = pos_ff; pn_in = pn_ff; pp_in = pp_ff; pp2_in = pp2_ff;
      pi_in = pi_ff; pip_in = pip_ff; ht_in = ht_ff;
      rv_in = rv_ff && !rsp_tready; rfs_in = 1'b0; rd_in = rd_ff; rflags_in = rflags_ff;
      sreq = '0;
      base = StoreAw'(d) * StoreAw'(DriveNibbles)
           + StoreAw'(trk_ff[d]) * StoreAw'(NibblesPerTrack) + StoreAw'(pos_ff[d]);
      ph = '0; ip = '0; ic = '0; np2 = '0; h = '0; tt = '0;
      if (acc) begin
         rv_in = 1'b1; rfs_in = 1'b0; rd_in = 8'd0;
         if (rtype == REQ_BUS) begin
            if (addr == ADDR_KBD) begin
               rd_in = key_ff;
            end else if (addr == ADDR_STROBE) begin
               key_in = {1'b0, key_ff[6:0]}; rd_in = key_in;
            end else if (addr == ADDR_LATCH) begin
               sreq.addr = base;
               if (wm_ff[d]) begin
                  sreq.wr = !wp_ff[d]; sreq.wdata = shl_ff; rd_in = shl_ff;
               end else begin
                  sreq.rd = 1'b1; rfs_in = 1'b1;
               end
               pos_in[d] = (32'(pos_ff[d]) + 1 >= NibblesPerTrack) ? '0
                         : PosW'(pos_ff[d] + 1'b1);
            end else if (addr == ADDR_RDMODE) begin
               wm_in[d] = 1'b0; rd_in = wp_ff[d] ? 8'h80 : 8'h00;
            end else begin
               tick_in = tick_ff + 8'd1; rd_in = tick_in;
               if (addr[15:3] == 13'h180A) begin
                  case (addr[2:1])
                     2'd0: text_in = addr[0];
                     2'd1: mixed_in = addr[0];
                     2'd2: page_in = addr[0];
                     default: hires_in = addr[0];
                  endcase
               end else if (addr[15:4] == 12'hC08) begin
                  bank_in = !addr[3];
                  rdr_in = (addr[1:0] == 2'd0) || (addr[1:0] == 2'd3);
                  if (!addr[0]) begin
                     wrr_in = 1'b0; pre_in = 1'b0;
                  end else begin
                     wrr_in = wrr_ff | pre_ff; pre_in = !iswr;
                  end
               end else if (addr[15:3] == 13'h181C) begin
                  ph = addr[2:1]; ip = pip_ff[d]; ic = pi_ff[d];
                  np2 = pp2_ff[d];
                  np2[ip] = pp_ff[d][ip];
                  pp2_in[d] = np2;
                  pp_in[d][ic] = pn_ff[d][ic];
                  pip_in[d] = ic; pi_in[d] = ph;
                  if (!addr[0]) begin
                     pn_in[d][ph] = 1'b0;
                  end else begin
                     h = ht_ff[d];
                     if (np2[ph + 2'd1] && h > 0) h = h - 1'b1;
                     if (np2[ph + 2'd3] && h < HalfW'(MaxHalfTrack)) h = h + 1'b1;
                     ht_in[d] = h;
                     pn_in[d][ph] = 1'b1;
                     tt = ({1'b0, h} + 1'b1) >> 1;
                     trk_in[d] = (32'(tt) > TrackCount - 1) ? TrackW'(TrackCount - 1)
                               : TrackW'(tt);
                     pos_in[d] = '0;
                  end
               end else if (addr == ADDR_MOTOFF || addr == ADDR_ROMOFF) begin
                  mot_in[d] = 1'b0;
               end else if (addr == ADDR_MOTON) begin
                  mot_in[d] = 1'b1;
               end else if (addr == ADDR_SEL0 || addr == ADDR_SEL1) begin
                  mot_in = '0;
                  mot_in[addr[0]] = mot_ff[0] | mot_ff[1];
                  drv_in = addr[0];
               end else if (addr == ADDR_LOAD) begin
                  shl_in = wdat;
               end else if (addr == ADDR_WRMODE) begin
                  wm_in[d] = 1'b1;
               end
            end
         end else if (rtype == REQ_KEY) begin
            key_in = kcode;
         end else if (rtype == REQ_LOAD) begin
            if (32'(ioff) < DriveNibbles) begin
               sreq.wr = 1'b1; sreq.wdata = ibyte;
               sreq.addr = StoreAw'(ldrv) * StoreAw'(DriveNibbles) + StoreAw'(ioff);
            end
         end
         rflags_in = {drv_in, mot_in[drv_in], wrr_in, rdr_in, bank_in,
                      hires_in, page_in, mixed_in, text_in};
      end else if (rfs_ff && rv_ff && !rsp_tready) begin
         // hold the store byte while the result stalls
         rfs_in = 1'b0; rd_in = srd;
      end
      // a completed store read lands in shift latch, unless a c0ed load is accepted now
      if (rfs_ff && !(acc && rtype == REQ_BUS && addr == ADDR_LOAD)) shl_in = srd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0; key_ff <= '0; shl_ff <= '0; tick_ff <= '0;
         text_ff <= 1'b1; mixed_ff <= 1'b0; page_ff <= 1'b0; hires_ff <= 1'b0;
         bank_ff <= 1'b0; rdr_ff <= 1'b0; wrr_ff <= 1'b0; pre_ff <= 1'b0;
         drv_ff <= 1'b0; mot_ff <= '0; wm_ff <= '0;
         for (int i = 0; i < 2; i++) begin
            trk_ff[i] <= '0; pos_ff[i] <= '0; pn_ff[i] <= '0; pp_ff[i] <= '0;
            pp2_ff[i] <= '0; pi_ff[i] <= '0; pip_ff[i] <= '0; ht_ff[i] <= '0;
         end
         rv_ff <= 1'b0; rfs_ff <= 1'b0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_paddr == CSR_WP) begin
            wp_ff <= csr_pwdata[1:0];
         end
         key_ff <= key_in; shl_ff <= shl_in; tick_ff <= tick_in;
         text_ff <= text_in; mixed_ff <= mixed_in; page_ff <= page_in; hires_ff <= hires_in;
         bank_ff <= bank_in; rdr_ff <= rdr_in; wrr_ff <= wrr_in; pre_ff <= pre_in;
         drv_ff <= drv_in; mot_ff <= mot_in; wm_ff <= wm_in;
         trk_ff <= trk_in; pos_ff <= pos_in; pn_ff <= pn_in; pp_ff <= pp_in;
         pp2_ff <= pp2_in; pi_ff <= pi_in; pip_ff <= pip_in; ht_ff <= ht_in;
         rv_ff <= rv_in; rfs_ff <= rfs_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_ff <= rd_in; rflags_ff <= rflags_in;
   end

   `FSSC_ASSERT_IMP(a_store_rd_valid, clock, reset, rfs_ff, rv_ff)
   `FSSC_ASSERT_IMP(a_motor_one, clock, reset, 1'b1, $onehot0(mot_ff))
   `FSSC_ASSERT_IMP(a_track_range, clock, reset, 1'b1,
      (32'(trk_ff[0]) < TrackCount) && (32'(trk_ff[1]) < TrackCount))
   `FSSC_ASSERT_NXT(a_stall_hold, clock, reset, rv_ff && !rsp_tready, rv_ff)
endmodule
`default_nettype wire

// ----- test/testbench.sv -----
// ----------------------------------------------------------------------------
// soft-switch controller testbench
// Drives bus accesses, key events and disk image loads into the block, with
// random gaps on both sides. Every result is checked against a predictor of
// the soft switches, the language card and the floppy controller. A short
// table of directed items runs first, then random traffic in which seven of twenty picks
// step the head and move nibbles under it. The write-protect bits change between
// phases while the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module testbench import fssc_pkg::*;;

   localparam logic [1:0] REQ_NONE = 2'd3;   // unknown request kind
   localparam logic [15:0] ADDR_PHASE0 = 16'hC0E0;
   localparam int QuietItems = 200;

   // one input item, split into its fields
   typedef struct {
      logic [1:0]  kind;
      logic [15:0] addr;
      logic        wr;
      logic [7:0]  wdata;
      logic [7:0]  key;
      logic        drv;
      logic [17:0] off;
      logic [7:0]  nib;
   } access_type;

   // one result, split into its fields
   typedef struct {
      logic [7:0] read_data;
      logic text, mixed, page, hires, bank, rdram, wrram, motor, drive;
   } status_type;

   typedef struct {
      access_type item;
      bit         typed;
      logic [7:0] exp_byte;
   } row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   // type[1:0] addr[17:2] wr[18] wdata[26:19] key[34:27] drv[35] off[53:36] byte[61:54]
   logic [63:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // read_data[7:0] text[8] mixed[9] page[10] hires[11] bank[12] rdram[13]
   // wrram[14] motor[15] drive[16]
   logic [23:0] rsp_tdata;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [0:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   floppy_soft_switch_controller u_top (.*);

   always #6 clock = ~clock;

   // ---------------------------------------------------------------------------
   // predictor state
   // ---------------------------------------------------------------------------
   logic [1:0]  wp_bits;
   logic [7:0]  key_latch, shift_latch, tick;
   logic        text_f, mixed_f, page_f, hires_f, sel_drive;
   logic        lc_bank, lc_read, lc_write, lc_pre;
   logic        motor [2], wmode [2];
   logic [5:0]  track [2];
   logic [12:0] npos [2];
   logic [3:0]  coil_now [2], coil_prev [2], coil_prev2 [2];
   logic [1:0]  coil_idx [2], coil_idx_prev [2];
   logic [6:0]  half_pos [2];
   logic [7:0]  disk_image [int];   // only entries that were loaded or written

   status_type expected_status [$];
   int errors = 0;
   int items_sent = 0, latch_reads = 0, latch_writes = 0, image_loads = 0;
   int results_seen = 0;
   bit quiet = 1'b0;               // no idling on either side near the end
   int stall_left = 0;

   function automatic int head_slot(logic d);
      return int'(d) * DriveNibbles + int'(track[d]) * NibblesPerTrack + int'(npos[d]);
   endfunction

   // stepper coil update of one drive
   task automatic step_coil(logic d, logic [2:0] a);
      logic [1:0] ph;
      logic [1:0] ip;
      logic [1:0] ic;
      int t;
      ph = a[2:1];
      ip = coil_idx_prev[d];
      ic = coil_idx[d];
      coil_prev2[d][ip] = coil_prev[d][ip];
      coil_prev[d][ic] = coil_now[d][ic];
      coil_idx_prev[d] = ic;
      coil_idx[d] = ph;
      if (!a[0]) begin
         coil_now[d][ph] = 1'b0;
         return;
      end
      // the coil above pulls the head out, the one below pulls it in
      if (coil_prev2[d][ph + 2'd1] && half_pos[d] > 0) half_pos[d]--;
      if (coil_prev2[d][ph + 2'd3] && half_pos[d] < MaxHalfTrack) half_pos[d]++;
      coil_now[d][ph] = 1'b1;
      t = (int'(half_pos[d]) + 1) / 2;
      if (t > TrackCount - 1) t = TrackCount - 1;
      track[d] = 6'(t);
      npos[d] = '0;
   endtask

   function automatic logic [7:0] bump_tick();
      tick = tick + 8'd1;
      return tick;
   endfunction

   // expected status after one item
   task automatic soft_switch_model(input access_type a, output status_type r);
      logic d;
      logic m;
      int slot;
      d = sel_drive;
      r.read_data = '0;
      if (a.kind == REQ_BUS) begin
         if (a.addr == ADDR_KBD) begin
            r.read_data = key_latch;
         end else if (a.addr == ADDR_STROBE) begin
            key_latch[7] = 1'b0;
            r.read_data = key_latch;
         end else if (a.addr == ADDR_LATCH) begin
            slot = head_slot(d);
            if (wmode[d]) begin
               if (!wp_bits[d]) disk_image[slot] = shift_latch;
            end else begin
               shift_latch = disk_image.exists(slot) ? disk_image[slot] : 8'h00;
            end
            npos[d] = (int'(npos[d]) + 1 >= NibblesPerTrack) ? '0 : npos[d] + 13'd1;
            r.read_data = shift_latch;
         end else if (a.addr == ADDR_RDMODE) begin
            wmode[d] = 1'b0;
            r.read_data = wp_bits[d] ? 8'h80 : 8'h00;
         end else begin
            if (a.addr >= 16'hC050 && a.addr <= 16'hC057) begin
               case (a.addr[2:1])
                  2'd0: text_f = a.addr[0];
                  2'd1: mixed_f = a.addr[0];
                  2'd2: page_f = a.addr[0];
                  default: hires_f = a.addr[0];
               endcase
            end else if (a.addr >= 16'hC080 && a.addr <= 16'hC08F) begin
               // bit 2 does not matter, bit 3 clear picks bank 2
               lc_bank = !a.addr[3];
               lc_read = (a.addr[1:0] == 2'd0 || a.addr[1:0] == 2'd3);
               if (a.addr[1:0] == 2'd0 || a.addr[1:0] == 2'd2) begin
                  lc_write = 1'b0;
                  lc_pre = 1'b0;
               end else begin
                  lc_write = lc_write | lc_pre;
                  lc_pre = !a.wr;
               end
            end else if (a.addr >= ADDR_PHASE0 && a.addr <= 16'hC0E7) begin
               step_coil(d, a.addr[2:0]);
            end else if (a.addr == ADDR_MOTOFF || a.addr == ADDR_ROMOFF) begin
               motor[d] = 1'b0;
            end else if (a.addr == ADDR_MOTON) begin
               motor[d] = 1'b1;
            end else if (a.addr == ADDR_SEL0 || a.addr == ADDR_SEL1) begin
               // the running motor follows the drive selection
               m = motor[0] | motor[1];
               motor[a.addr[0]] = m;
               motor[!a.addr[0]] = 1'b0;
               sel_drive = a.addr[0];
            end else if (a.addr == ADDR_LOAD) begin
               shift_latch = a.wdata;
            end else if (a.addr == ADDR_WRMODE) begin
               wmode[d] = 1'b1;
            end
            r.read_data = bump_tick();
         end
      end else if (a.kind == REQ_KEY) begin
         key_latch = a.key;
      end else if (a.kind == REQ_LOAD) begin
         if (int'(a.off) < DriveNibbles) disk_image[int'(a.drv) * DriveNibbles + int'(a.off)] = a.nib;
      end
      d = sel_drive;
      r.text = text_f;
      r.mixed = mixed_f;
      r.page = page_f;
      r.hires = hires_f;
      r.bank = lc_bank;
      r.rdram = lc_read;
      r.wrram = lc_write;
      r.motor = motor[d];
      r.drive = d;
   endtask

   // ---------------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------------
   function automatic access_type bus(logic [15:0] a, logic w, logic [7:0] wd);
      access_type x = '{default: '0};
      x.kind = REQ_BUS;
      x.addr = a;
      x.wr = w;
      x.wdata = wd;
      return x;
   endfunction

   function automatic access_type load(logic d, logic [17:0] o, logic [7:0] b);
      access_type x = '{default: '0};
      x.kind = REQ_LOAD;
      x.drv = d;
      x.off = o;
      x.nib = b;
      return x;
   endfunction

   // one transfer on the request channel, with an optional idle burst after it
   task automatic send(input access_type a, input bit typed, input logic [7:0] exp_byte);
      status_type r;
      soft_switch_model(a, r);
      if (typed) r.read_data = exp_byte;
      expected_status.push_back(r);
      req_tdata <= {2'b00, a.nib, a.off, a.drv, a.key, a.wdata, a.wr, a.addr, a.kind};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      items_sent++;
      if (a.kind == REQ_LOAD) image_loads++;
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   // a latch read must find a nibble under the head, so load one there first
   task automatic issue(input access_type a);
      logic d;
      d = sel_drive;
      if (a.kind == REQ_BUS && a.addr == ADDR_LATCH) begin
         if (wmode[d]) latch_writes++;
         else begin
            latch_reads++;
            if (!disk_image.exists(head_slot(d)))
               send(load(d, 18'(int'(track[d]) * NibblesPerTrack + int'(npos[d])),
                         8'($urandom)), 1'b0, '0);
         end
      end
      send(a, 1'b0, '0);
   endtask

   task automatic wait_drained();
      while (expected_status.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(logic [1:0] value);
      req_tvalid <= 1'b0;
      wait_drained();
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_WP;
      csr_pwdata <= 32'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      wp_bits = value;
      @(posedge clock);
   endtask

   // walk the coils of the selected drive one way, then work the track
   task automatic seek_and_work();
      logic [1:0] coil;
      logic [1:0] dirn;
      int n;
      coil = coil_idx[sel_drive];
      dirn = $urandom_range(0, 1) ? 2'd1 : 2'd3;
      n = $urandom_range(1, 8);
      for (int k = 0; k < n; k++) begin
         issue(bus(ADDR_PHASE0 + 16'(2 * int'(2'(coil + dirn))) + 16'd1, 1'($urandom),
                   8'($urandom)));
         issue(bus(ADDR_PHASE0 + 16'(2 * int'(coil)), 1'($urandom), 8'($urandom)));
         coil = coil + dirn;
      end
      n = $urandom_range(2, 10);
      for (int k = 0; k < n; k++) begin
         case ($urandom_range(0, 7))
            0: issue(bus(ADDR_LOAD, 1'($urandom), 8'($urandom)));
            1: issue(bus(ADDR_WRMODE, 1'($urandom), 8'($urandom)));
            2: issue(bus(ADDR_RDMODE, 1'($urandom), 8'($urandom)));
            default: issue(bus(ADDR_LATCH, 1'($urandom), 8'($urandom)));
         endcase
      end
   endtask

   function automatic logic [15:0] pick_addr();
      case ($urandom_range(0, 9))
         0: return 16'($urandom);
         1: return 16'hC050 + 16'($urandom_range(0, 7));
         2, 3: return 16'hC080 + 16'($urandom_range(0, 15));
         4, 5: return ADDR_PHASE0 + 16'($urandom_range(0, 15));
         6: return $urandom_range(0, 1) ? ADDR_KBD : ADDR_STROBE;
         7: return $urandom_range(0, 1) ? ADDR_ROMOFF : ADDR_MOTON;
         8: return $urandom_range(0, 1) ? ADDR_SEL0 : ADDR_SEL1;
         default: return 16'hC000 + 16'($urandom_range(0, 255));
      endcase
   endfunction

   // ---------------------------------------------------------------------------
   // result side: random back-pressure and the checker
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      if (quiet || reset) begin
         stall_left = 0;
      end else if (stall_left == 0 && $urandom_range(0, 6) == 0) begin
         stall_left = $urandom_range(1, 4);
      end else if (stall_left > 0) begin
         stall_left--;
      end
      rsp_tready <= (stall_left == 0);
   end

   function automatic void check_field(string name, int exp_v, int act_v);
      if (exp_v != act_v) begin
         $error("%s: expected %0h, got %0h", name, exp_v, act_v);
         errors++;
      end
   endfunction

   always @(posedge clock) begin
      status_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (expected_status.size() == 0) begin
            $error("result transfer with nothing expected: %h", rsp_tdata);
            errors++;
         end else begin
            e = expected_status.pop_front();
            check_field("read_data", e.read_data, rsp_tdata[7:0]);
            check_field("text_on", e.text, rsp_tdata[8]);
            check_field("mixed_on", e.mixed, rsp_tdata[9]);
            check_field("page_two", e.page, rsp_tdata[10]);
            check_field("hires_on", e.hires, rsp_tdata[11]);
            check_field("bank_two", e.bank, rsp_tdata[12]);
            check_field("ram_read", e.rdram, rsp_tdata[13]);
            check_field("ram_write", e.wrram, rsp_tdata[14]);
            check_field("motor_running", e.motor, rsp_tdata[15]);
            check_field("drive_selected", e.drive, rsp_tdata[16]);
         end
      end
   end

   // ---------------------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------------------
   initial begin
      row_type rows [$];
      access_type x;
      int budget;
      logic [1:0] wp_plan [4] = '{2'd3, 2'd1, 2'd2, 2'd0};

      // predictor reset state
      wp_bits = '0; key_latch = '0; shift_latch = '0; tick = '0;
      text_f = 1'b1; mixed_f = 1'b0; page_f = 1'b0; hires_f = 1'b0; sel_drive = 1'b0;
      lc_bank = 1'b0; lc_read = 1'b0; lc_write = 1'b0; lc_pre = 1'b0;
      for (int d = 0; d < 2; d++) begin
         motor[d] = 1'b0; wmode[d] = 1'b0; track[d] = '0; npos[d] = '0;
         coil_now[d] = '0; coil_prev[d] = '0; coil_prev2[d] = '0;
         coil_idx[d] = '0; coil_idx_prev[d] = '0; half_pos[d] = '0;
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table: keyboard, tick, video, language card, unknown request, image loads, disk basics
      x = '{default: '0}; x.kind = REQ_KEY; x.key = 8'hFF;
      rows.push_back('{bus(ADDR_KBD, 1'b0, 8'h00), 1'b1, 8'h00});
      rows.push_back('{bus(16'hFFFF, 1'b1, 8'hFF), 1'b1, 8'h01});   // unmatched bumps tick
      rows.push_back('{bus(16'h0000, 1'b0, 8'h00), 1'b1, 8'h02});
      rows.push_back('{x, 1'b1, 8'h00});
      rows.push_back('{bus(ADDR_KBD, 1'b0, 8'h00), 1'b1, 8'hFF});
      rows.push_back('{bus(ADDR_STROBE, 1'b1, 8'h00), 1'b1, 8'h7F});  // strobe clear
      for (int i = 0; i < 8; i++) rows.push_back('{bus(16'hC050 + 16'(i), 1'b0, 8'h00), 1'b0, 8'h00});
      rows.push_back('{bus(16'hC081, 1'b0, 8'h00), 1'b0, 8'h00});    // pre-write armed
      rows.push_back('{bus(16'hC08F, 1'b0, 8'h00), 1'b0, 8'h00});    // write enable
      rows.push_back('{bus(16'hC084, 1'b1, 8'h00), 1'b0, 8'h00});
      x = '{default: '0}; x.kind = REQ_NONE; x.addr = 16'hFFFF;
      rows.push_back('{x, 1'b1, 8'h00});                              // unknown request
      rows.push_back('{load(1'b0, 18'd232960, 8'hEE), 1'b1, 8'h00}); // out of range load
      rows.push_back('{load(1'b1, 18'h3FFFF, 8'hFF), 1'b1, 8'h00});
      rows.push_back('{load(1'b1, 18'd232959, 8'hFF), 1'b1, 8'h00}); // last nibble of image
      rows.push_back('{load(1'b0, 18'd0, 8'hA5), 1'b1, 8'h00});
      rows.push_back('{bus(ADDR_LATCH, 1'b0, 8'h00), 1'b1, 8'hA5});
      rows.push_back('{bus(ADDR_LOAD, 1'b1, 8'h3C), 1'b0, 8'h00});
      rows.push_back('{bus(ADDR_WRMODE, 1'b0, 8'h00), 1'b0, 8'h00});
      rows.push_back('{bus(ADDR_LATCH, 1'b0, 8'h00), 1'b1, 8'h3C});
      rows.push_back('{bus(ADDR_RDMODE, 1'b0, 8'h00), 1'b1, 8'h00});
      foreach (rows[i]) send(rows[i].item, rows[i].typed, rows[i].exp_byte);

      // random phases, each under its own write-protect setting
      for (int ph = 0; ph < 4; ph++) begin
         csr_write(wp_plan[ph]);
         budget = items_sent + 425;
         while (items_sent < budget) begin
            if (ph == 3 && budget - items_sent < QuietItems) quiet = 1'b1;
            case ($urandom_range(0, 19))
               0, 1: issue(load(1'($urandom), 18'($urandom), 8'($urandom)));
               2: begin
                  x = '{default: '0}; x.kind = REQ_KEY; x.key = 8'($urandom);
                  issue(x);
               end
               3: begin
                  x = '{default: '0}; x.kind = REQ_NONE; x.addr = 16'($urandom);
                  issue(x);
               end
               4, 5, 6, 7, 8, 9, 10: seek_and_work();
               default: issue(bus(pick_addr(), 1'($urandom), 8'($urandom)));
            endcase
         end
      end

      req_tvalid <= 1'b0;
      while (expected_status.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      $display("covered %0d items (%0d image loads), %0d nibble reads, %0d nibble writes",
               items_sent, image_loads, latch_reads, latch_writes);
      $display("checked %0d results over four write-protect settings", results_seen);
      if (errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   // run limit
   initial begin
      #5ms;
      $display("DONE: errors detected");
      $finish;
   end
endmodule
